[rtl/rbd_pkg.sv]
package rbd_pkg;

  // Ring geometry and element width.
  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned ELEM_BITS = 32;
  localparam int unsigned PTR_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 2;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = ((OP_W + ELEM_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((ELEM_BITS + PTR_W + STATUS_W + CNT_W + 7) / 8) * 8;

  // Requested operation.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_SHIFT   = 2'd2,
    OP_UNSHIFT = 2'd3
  } rbd_op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_UNUSED = 2'd3
  } rbd_status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } rbd_state_e;

  // Request from the sequencer to the pointer unit.
  typedef struct packed {
    logic    valid;
    rbd_op_e op;
  } rbd_req_t;

  // Pointer unit answer for the current request.
  typedef struct packed {
    logic [PTR_W-1:0] slot;
    rbd_status_e      status;
    logic [CNT_W-1:0] count;
    logic             mem_we;
    logic             mem_re;
  } rbd_res_t;

endpackage

[rtl/rbd_ram.sv]
module rbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port with a registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rbd_ptr.sv]
module rbd_ptr import rbd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rbd_req_t req_i,
  output rbd_res_t res_o
);

  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [PTR_W-1:0] head_next, head_prev, tail_next, tail_prev;
  logic [CNT_W-1:0] count_q, count_d;
  logic             adding, full, empty;

  // Neighbor slots with wraparound at the ring capacity.
  assign head_next = (head_q == PTR_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
  assign head_prev = (head_q == '0) ? PTR_W'(CAPACITY - 1) : head_q - 1'b1;
  assign tail_next = (tail_q == PTR_W'(CAPACITY - 1)) ? '0 : tail_q + 1'b1;
  assign tail_prev = (tail_q == '0) ? PTR_W'(CAPACITY - 1) : tail_q - 1'b1;

  assign adding = (req_i.op == OP_PUSH) || (req_i.op == OP_UNSHIFT);
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign empty  = (count_q == '0);

  // Decide the slot, status and pointer moves for the requested operation.
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    res_o.slot    = '0;
    res_o.status  = ST_DONE;
    res_o.mem_we  = 1'b0;
    res_o.mem_re  = 1'b0;
    if (adding && full) begin
      res_o.status = ST_FULL;
    end else if (!adding && empty) begin
      res_o.status = ST_EMPTY;
    end else begin
      unique case (req_i.op)
        OP_PUSH: begin
          res_o.slot   = tail_q;
          res_o.mem_we = 1'b1;
          tail_d       = tail_next;
          count_d      = count_q + 1'b1;
        end
        OP_POP: begin
          res_o.slot   = tail_prev;
          res_o.mem_re = 1'b1;
          tail_d       = tail_prev;
          count_d      = count_q - 1'b1;
        end
        OP_SHIFT: begin
          res_o.slot   = head_q;
          res_o.mem_re = 1'b1;
          head_d       = head_next;
          count_d      = count_q - 1'b1;
        end
        OP_UNSHIFT: begin
          res_o.slot   = head_prev;
          res_o.mem_we = 1'b1;
          head_d       = head_prev;
          count_d      = count_q + 1'b1;
        end
        default: begin
          res_o.slot = '0;
        end
      endcase
    end
    res_o.count = count_d;
  end

  // Pointers and count move only when a request is committed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (req_i.valid) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

[rtl/ring_buffer_deque.sv]
// Result: a push, unshift or refused operation shows its result beat in the cycle after
// acceptance; a successful pop or shift first passes through S_READ for the RAM read, then S_OUT.
// Flow: one item at a time; no new beat is accepted until the result beat of the last one
// has been taken with m_axis_tready.
// Reset: head, tail and count clear to zero at once; the element store is not cleared.
module ring_buffer_deque import rbd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // op [1:0], element_in [33:2], zero padding above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // element_out [31:0], slot_index [35:32], status [37:36], fill_count [42:38], zero above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  rbd_state_e           state_q, state_d;
  rbd_req_t             req;
  rbd_res_t             res;
  logic                 in_beat;
  logic [ELEM_BITS-1:0] elem_in, rdata;
  logic [ELEM_BITS-1:0] elem_q, elem_d;
  logic [PTR_W-1:0]     slot_q;
  rbd_status_e          status_q;
  logic [CNT_W-1:0]     fill_q;

  assign elem_in   = s_axis_tdata[OP_W +: ELEM_BITS];
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign req.valid = in_beat;
  assign req.op    = rbd_op_e'(s_axis_tdata[OP_W-1:0]);

  rbd_ptr u_ptr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  rbd_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_beat && res.mem_we),
    .re_i    (in_beat && res.mem_re),
    .addr_i  (res.slot),
    .wdata_i (elem_in),
    .rdata_o (rdata)
  );

  // Sequencer: take one beat, wait for the read if any, then offer the result.
  always_comb begin
    state_d       = state_q;
    elem_d        = elem_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          elem_d  = '0;
          state_d = res.mem_re ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        elem_d  = rdata;
        state_d = S_OUT;
      end
      S_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    if (in_beat) begin
      slot_q   <= res.slot;
      status_q <= res.status;
      fill_q   <= res.count;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({fill_q, status_q, slot_q, elem_q});

endmodule
